FILE: rtl/core/register_pool_belady_allocator_core_macros.svh
// assertion macros for the register pool allocator
`ifndef REGISTER_POOL_BELADY_ALLOCATOR_CORE_MACROS_SVH
`define REGISTER_POOL_BELADY_ALLOCATOR_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RPBA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/rpba_pkg.sv
// package: types, constants and op codes for the register pool allocator
package rpba_pkg;
  localparam int unsigned MaxValues = 1024;
  localparam int unsigned PoolRegs = 32;
  localparam int unsigned MaxPhysReg = 64;
  localparam int unsigned VidW = $clog2(MaxValues);
  localparam int unsigned PosW = $clog2(PoolRegs);
  localparam int unsigned PhysW = $clog2(MaxPhysReg);

  typedef enum logic [2:0] {
    OP_DEFINE = 3'd0, OP_ENSURE = 3'd1, OP_FREE = 3'd2,
    OP_CLAIM = 3'd3, OP_UNPIN = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    LK_NONE = 2'd0, LK_FILL = 2'd1, LK_REMAT = 2'd2
  } load_kind_e;

  typedef enum logic [1:0] {
    CFG_POOL_FIRST = 2'd0, CFG_POOL_COUNT = 2'd1, CFG_REMAT_EN = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SEARCH, ST_EVICT, ST_COMMIT, ST_OUT
  } state_e;

  // per-value record held in the value memory
  typedef struct packed {
    logic            pos_ok;
    logic [PosW-1:0] pos;
    logic            slot_ok;
    logic [9:0]      slot;
    logic [11:0]     lu;
    logic            remat;
  } vrec_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  value_id;
    logic [9:0]  source_value;
    logic [11:0] last_ref;
    logic        is_constant;
  } req_t;

  typedef struct packed {
    logic [5:0] reg_res;
    logic       spilled;
    logic [5:0] spill_reg;
    logic [9:0] spill_slot;
    logic [1:0] load_kind;
    logic [9:0] load_slot;
    logic       error;
  } res_t;

  // eviction key: negative last use counts as farthest
  function automatic logic [12:0] evict_key(input logic [11:0] lu);
    evict_key = lu[11] ? 13'd4096 : {1'b0, lu};
  endfunction
endpackage

FILE: rtl/core/rpba_if.sv
// valid/ready channel interfaces
interface rpba_req_if;
  import rpba_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rpba_res_if;
  import rpba_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rpba_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [5:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/rpba_vmem.sv
// value table memory with clearing pass after reset
module rpba_vmem import rpba_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [VidW-1:0] raddr_i,
  output vrec_t           rdata_o,
  input  logic            we_i,
  input  logic [VidW-1:0] waddr_i,
  input  vrec_t           wdata_i,
  output logic            busy_o
);
  vrec_t mem [MaxValues];
  logic [VidW:0] clr_q, clr_d;

  // clearing pass counter
  assign busy_o = !clr_q[VidW];
  assign clr_d = busy_o ? clr_q + 1'b1 : clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else clr_q <= clr_d;
  end

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (busy_o) mem[clr_q[VidW-1:0]] <= '0;
    else if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/core/register_pool_belady_allocator_core.sv
// top level: register pool allocator with farthest-use eviction
//  channel | dir | fields
//  req     | in  | op, value_id, source_value, last_ref, is_constant
//  res     | out | reg_res, spilled, spill_reg, spill_slot, load_kind, load_slot, error
//  cfg     | in  | index, wdata
// an item passes through idle, the value-memory reads (value, then source),
// search, commit and output before the next is taken; a full pool adds an
// eviction state that reads and rewrites the victim record, a claim that moves
// a register adds a step there to rewrite the source record, and an allocation
// error skips commit. after reset a clearing pass runs over all 1024 entries of
// the value memory; no item is taken then. a stalled result waits in its output register.
module register_pool_belady_allocator_core import rpba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rpba_req_if.sink   req,
  rpba_res_if.source res,
  rpba_cfg_if.sink   cfg
);
`include "register_pool_belady_allocator_core_macros.svh"

  state_e state_q, state_d;
  req_t req_q;
  res_t res_q, res_d;
  logic [5:0] pool_first_q, pool_count_q;
  logic remat_en_q;
  logic [PoolRegs-1:0] free_q, free_d, pin_q, pin_d, own_ok_q, own_ok_d;
  logic [VidW-1:0] owner_q [PoolRegs];
  logic [VidW-1:0] owner_w;
  logic [PosW-1:0] owner_wpos;
  logic owner_we;
  logic [12:0] key_q [PoolRegs];
  logic [12:0] key_w;
  logic key_we;
  logic [10:0] next_slot_q, next_slot_d;
  vrec_t vrec_q, vrec_d;   // record of value_id
  vrec_t srec_q, srec_d;   // record of source or victim
  logic [1:0] rd_step_q, rd_step_d;
  logic [PosW-1:0] best_q, best_d;
  logic [VidW-1:0] raddr;
  vrec_t rdata, wdata;
  logic we, busy;
  logic [VidW-1:0] waddr;
  logic [PoolRegs-1:0] mask;

  rpba_vmem u_vmem (
    .clk_i, .rst_ni, .raddr_i(raddr), .rdata_o(rdata), .we_i(we),
    .waddr_i(waddr), .wdata_i(wdata), .busy_o(busy)
  );

  // pool mask
  always_comb begin
    logic [5:0] n;
    n = (pool_count_q > 6'(PoolRegs)) ? 6'(PoolRegs) : pool_count_q;
    for (int i = 0; i < PoolRegs; i++) mask[i] = (6'(i) < n);
  end

  function automatic logic [5:0] phys(input logic [5:0] first, input logic [PosW-1:0] p);
    logic [6:0] s;
    s = 7'(first) + 7'(p);
    phys = s[PhysW-1:0];
  endfunction

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == ST_IDLE) && !busy;
  assign res.valid = (state_q == ST_OUT);
  assign res.data = res_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_first_q <= '0; pool_count_q <= 6'd16; remat_en_q <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_POOL_FIRST: pool_first_q <= cfg.wdata;
        CFG_POOL_COUNT: pool_count_q <= cfg.wdata;
        CFG_REMAT_EN:   remat_en_q <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // victim search: binary compare tree, the lower position wins a tie
  logic [PoolRegs-1:0] cand;
  logic [12:0] t_key [2*PoolRegs-1];
  logic [PosW-1:0] t_pos [2*PoolRegs-1];
  logic t_ok [2*PoolRegs-1];
  logic [PosW-1:0] s_best;
  logic s_ok;
  always_comb begin
    cand = mask & ~pin_q & own_ok_q;
    for (int i = 0; i < PoolRegs; i++) begin
      t_ok[PoolRegs-1+i] = cand[i];
      t_key[PoolRegs-1+i] = key_q[i];
      t_pos[PoolRegs-1+i] = PosW'(i);
    end
    // left child covers the lower positions
    for (int n = PoolRegs - 2; n >= 0; n--) begin
      if (t_ok[2*n+2] && (!t_ok[2*n+1] || t_key[2*n+2] > t_key[2*n+1])) begin
        t_ok[n] = 1'b1; t_key[n] = t_key[2*n+2]; t_pos[n] = t_pos[2*n+2];
      end else begin
        t_ok[n] = t_ok[2*n+1]; t_key[n] = t_key[2*n+1]; t_pos[n] = t_pos[2*n+1];
      end
    end
    s_ok = t_ok[0];
    s_best = t_pos[0];
  end

  logic [PoolRegs-1:0] avail;
  logic [PosW-1:0] low_free;
  always_comb begin
    avail = free_q & mask;
    low_free = '0;
    for (int i = PoolRegs - 1; i >= 0; i--) if (avail[i]) low_free = PosW'(i);
  end

  logic alloc_op;
  assign alloc_op = (req_q.op == OP_DEFINE) ||
                    (req_q.op == OP_ENSURE && !vrec_q.pos_ok);

  // control and datapath
  always_comb begin
    logic [PosW-1:0] p;
    state_d = state_q; res_d = res_q;
    free_d = free_q; pin_d = pin_q; own_ok_d = own_ok_q;
    next_slot_d = next_slot_q;
    vrec_d = vrec_q; srec_d = srec_q;
    rd_step_d = rd_step_q; best_d = best_q;
    raddr = req_q.value_id; we = 1'b0; waddr = req_q.value_id; wdata = vrec_q;
    owner_we = 1'b0; owner_wpos = '0; owner_w = req_q.value_id;
    key_we = 1'b0; key_w = evict_key(req_q.last_ref);
    p = '0;
    unique case (state_q)
      ST_IDLE: begin
        rd_step_d = 2'd0;
        if (req.valid && !busy) state_d = ST_READ;
      end
      ST_READ: begin
        // step 0 issues value read, 1 captures it and issues source read
        rd_step_d = rd_step_q + 2'd1;
        raddr = (rd_step_q == 2'd0) ? req_q.value_id : req_q.source_value;
        if (rd_step_q == 2'd1) vrec_d = rdata;
        if (rd_step_q == 2'd2) begin
          srec_d = rdata;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        res_d = '0;
        // a define first releases the value's own register
        if (req_q.op == OP_DEFINE && vrec_q.pos_ok) begin
          free_d[vrec_q.pos] = 1'b1; own_ok_d[vrec_q.pos] = 1'b0;
          vrec_d.pos_ok = 1'b0;
        end
        if (alloc_op) begin
          if (req_q.op == OP_DEFINE && vrec_q.pos_ok && mask[vrec_q.pos]) begin
            best_d = (avail != '0 && low_free < vrec_q.pos) ? low_free : vrec_q.pos;
            if (!(avail != '0 && low_free < vrec_q.pos)) free_d[vrec_q.pos] = 1'b0;
            else free_d[low_free] = 1'b0;
            state_d = ST_COMMIT;
          end else if (avail != '0) begin
            best_d = low_free; free_d[low_free] = 1'b0; state_d = ST_COMMIT;
          end else if (s_ok) begin
            best_d = s_best;
            rd_step_d = 2'd0; state_d = ST_EVICT;
          end else begin
            res_d.error = 1'b1;
            we = (req_q.op == OP_DEFINE); wdata = vrec_d;
            state_d = ST_OUT;
          end
        end else state_d = ST_COMMIT;
      end
      ST_EVICT: begin
        // read victim record, then update it
        raddr = owner_q[best_q];
        rd_step_d = rd_step_q + 2'd1;
        if (rd_step_q == 2'd1) begin
          srec_d = rdata;
          srec_d.pos_ok = 1'b0;
          if (remat_en_q && rdata.remat) srec_d.slot_ok = 1'b0;
          else begin
            if (!rdata.slot_ok) begin
              srec_d.slot = next_slot_q[9:0]; srec_d.slot_ok = 1'b1;
              next_slot_d = next_slot_q + 11'd1;
            end
            res_d.spilled = 1'b1;
            res_d.spill_reg = phys(pool_first_q, best_q);
            res_d.spill_slot = srec_d.slot;
          end
          own_ok_d[best_q] = 1'b0;
          we = 1'b1; waddr = owner_q[best_q]; wdata = srec_d;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_d = ST_OUT;
        unique case (req_q.op)
          OP_DEFINE: begin
            vrec_d.pos_ok = 1'b1; vrec_d.pos = best_q;
            vrec_d.lu = req_q.last_ref; vrec_d.remat = req_q.is_constant;
            own_ok_d[best_q] = 1'b1; pin_d[best_q] = 1'b1;
            owner_we = 1'b1; owner_wpos = best_q; key_we = 1'b1;
            res_d.reg_res = phys(pool_first_q, best_q);
            we = 1'b1; wdata = vrec_d;
          end
          OP_ENSURE: begin
            if (vrec_q.pos_ok) begin
              pin_d[vrec_q.pos] = 1'b1;
              res_d.reg_res = phys(pool_first_q, vrec_q.pos);
            end else begin
              if (vrec_q.slot_ok) begin
                res_d.load_kind = LK_FILL; res_d.load_slot = vrec_q.slot;
              end else if (remat_en_q && vrec_q.remat) res_d.load_kind = LK_REMAT;
              vrec_d.pos_ok = 1'b1; vrec_d.pos = best_q;
              own_ok_d[best_q] = 1'b1; pin_d[best_q] = 1'b1;
              owner_we = 1'b1; owner_wpos = best_q;
              key_we = 1'b1; key_w = evict_key(vrec_q.lu);
              res_d.reg_res = phys(pool_first_q, best_q);
              we = 1'b1; wdata = vrec_d;
            end
          end
          OP_FREE: if (vrec_q.pos_ok) begin
            free_d[vrec_q.pos] = 1'b1; own_ok_d[vrec_q.pos] = 1'b0;
            vrec_d.pos_ok = 1'b0; we = 1'b1; wdata = vrec_d;
          end
          OP_CLAIM: if (srec_q.pos_ok) begin
            p = srec_q.pos;
            if (req_q.value_id != req_q.source_value && vrec_q.pos_ok) begin
              free_d[vrec_q.pos] = 1'b1; own_ok_d[vrec_q.pos] = 1'b0;
            end
            own_ok_d[p] = 1'b1; pin_d[p] = 1'b1;
            vrec_d.pos_ok = 1'b1; vrec_d.pos = p;
            vrec_d.lu = req_q.last_ref; vrec_d.remat = req_q.is_constant;
            owner_we = 1'b1; owner_wpos = p; key_we = 1'b1;
            res_d.reg_res = phys(pool_first_q, p);
            we = 1'b1; wdata = vrec_d;
            // source record loses its register in the next state
            state_d = (req_q.value_id != req_q.source_value) ? ST_EVICT : ST_OUT;
            rd_step_d = 2'd3;
          end
          OP_UNPIN: pin_d = '0;
          default: ;
        endcase
      end
      ST_OUT: if (res.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    // claim follow-up: write the source record without its register
    if (state_q == ST_EVICT && rd_step_q == 2'd3) begin
      raddr = req_q.value_id;
      rd_step_d = rd_step_q;
      srec_d = srec_q; srec_d.pos_ok = 1'b0;
      we = 1'b1; waddr = req_q.source_value; wdata = srec_d;
      next_slot_d = next_slot_q; res_d = res_q; own_ok_d = own_ok_q;
      state_d = ST_OUT;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; free_q <= '1; pin_q <= '0; own_ok_q <= '0;
      next_slot_q <= '0; rd_step_q <= '0;
    end else begin
      state_q <= state_d; free_q <= free_d; pin_q <= pin_d; own_ok_q <= own_ok_d;
      next_slot_q <= next_slot_d; rd_step_q <= rd_step_d;
    end
  end

  // payload registers; the result is cleared in the search cycle
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.data;
    res_q <= res_d;
    vrec_q <= vrec_d; srec_q <= srec_d; best_q <= best_d;
    if (owner_we) owner_q[owner_wpos] <= owner_w;
    if (key_we) key_q[owner_wpos] <= key_w;
  end

  `RPBA_ASSERT(a_res_only_out, res.valid, state_q == ST_OUT, "result outside output state")
  `RPBA_ASSERT(a_no_accept_busy, busy, !req.ready, "item taken during clearing")
  `RPBA_ASSERT_NEXT(a_out_hold, res.valid && !res.ready, res.valid && $stable(res.data),
    "result dropped while stalled")
  `RPBA_ASSERT(a_spill_err, res.valid && res.data.error, !res.data.spilled,
    "spill reported with error")
endmodule
